FILE: design/cn3d_pkg.sv
package cn3d_pkg;

   localparam logic [31:0] HashMulX    = 32'h27d4eb2d;
   localparam logic [31:0] HashMulY    = 32'h165667b1;
   localparam logic [31:0] HashMulZ    = 32'h9e3779b9;
   localparam logic [31:0] HashMulMix  = 32'h85ebca6b;
   localparam int          WorkFrac    = 24;
   localparam int          NumCells    = 27;
   localparam int          SqWidth     = 50;
   localparam int          OutWidth    = 17;
   localparam int          RootWidth   = 26;
   localparam int          RootSteps   = 17;
   localparam logic [OutWidth-1:0] OutMax = 17'd65536;

   // Per-cell work item travelling down the chain
   typedef struct packed {
      logic        valid;
      logic [31:0] cell_x;
      logic [31:0] cell_y;
      logic [31:0] cell_z;
      logic [24:0] frac_x;
      logic [24:0] frac_y;
      logic [24:0] frac_z;
      logic [31:0] seed;
      logic [SqWidth-1:0] best;
   } cn3d_item_type;

   // Square root chain item
   typedef struct packed {
      logic                 valid;
      logic [SqWidth-1:0]   rem;
      logic [RootWidth-1:0] root;
   } cn3d_root_type;

endpackage

FILE: design/cellular_noise_3d_top.sv
// Cellular noise, 3D, nearest-feature distance.
// Requests carry a signed fixed-point point on req_coord_x/y/z with req_valid/req_ready.
// Results leave on rsp_nearest_distance with rsp_valid/rsp_ready, Q1.16, 65536 = 1.0.
// csr_write_enable loads csr_hash_seed (reset value 255); write only when idle.
// Throughput: one request per cycle unless the output stalls. The 27 neighbor
// cells form a chain, each a five-register cell (hash multiplies, seed xor,
// mix multiply, per-axis squares, sum and compare); a 17-stage one-bit-per-stage
// square root follows.
// The whole chain advances only when the output register is empty or taken,
// so a stalled receiver freezes it and drops req_ready; nothing is lost.
// Reset clears all valid flags and restores the seed.
module cellular_noise_3d_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [31:0] req_coord_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_nearest_distance,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_hash_seed
);
   import cn3d_pkg::*;

   logic [31:0]   seed_ff;
   logic          advance;
   cn3d_item_type head;
   cn3d_item_type chain [NumCells+1];
   cn3d_root_type rchain [RootSteps+1];
   logic [16:0]   dist_ff;
   logic          out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) seed_ff <= 32'd255;
      else if (csr_write_enable) seed_ff <= csr_hash_seed;
   end

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   function automatic logic [31:0] cell_of(input logic [31:0] c);
      cell_of = 32'($signed(c) >>> FRAC_BITS);
   endfunction

   function automatic logic [24:0] frac_of(input logic [31:0] c);
      logic [31:0] m;
      begin
         m = c & ((32'd1 << FRAC_BITS) - 32'd1);
         frac_of = 25'(m << (WorkFrac - FRAC_BITS));
      end
   endfunction

   always_comb begin
      head.valid  = req_valid;
      head.cell_x = cell_of(req_coord_x);
      head.cell_y = cell_of(req_coord_y);
      head.cell_z = cell_of(req_coord_z);
      head.frac_x = frac_of(req_coord_x);
      head.frac_y = frac_of(req_coord_y);
      head.frac_z = frac_of(req_coord_z);
      head.seed   = seed_ff;
      head.best   = {SqWidth{1'b1}};
   end

   assign chain[0] = head;

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      cn3d_cell #(
         .DX(i / 9 - 1),
         .DY((i / 3) % 3 - 1),
         .DZ(i % 3 - 1)
      ) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .item_in(chain[i]), .item_out(chain[i+1])
      );
   end

   always_comb begin
      rchain[0].valid = chain[NumCells].valid;
      rchain[0].rem   = {16'd0, chain[NumCells].best[SqWidth-1:16]};
      rchain[0].root  = '0;
   end

   for (genvar j = 0; j < RootSteps; j++) begin : g_root
      cn3d_root #(.STEP(j)) u_root (
         .clock(clock), .reset(reset), .advance(advance),
         .item_in(rchain[j]), .item_out(rchain[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rchain[RootSteps].valid;
         dist_ff <= (rchain[RootSteps].root > 26'(OutMax)) ? OutMax
                    : rchain[RootSteps].root[16:0];
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_nearest_distance = dist_ff;
endmodule

FILE: design/cn3d_cell.sv
// One neighbor cell: hash in three registered steps, then distance compare.
// Every cell delays its item by the same depth, so items march in lockstep.
module cn3d_cell #(
   parameter int DX = 0,
   parameter int DY = 0,
   parameter int DZ = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cn3d_pkg::cn3d_item_type item_in,
   output cn3d_pkg::cn3d_item_type item_out
);
   import cn3d_pkg::*;

   localparam logic [31:0] OffX = 32'(DX);
   localparam logic [31:0] OffY = 32'(DY);
   localparam logic [31:0] OffZ = 32'(DZ);

   cn3d_item_type s1_ff, s2_ff, s3_ff, s4_ff;
   cn3d_item_type out_in;
   logic [31:0]   h1_ff, h1_in;
   logic [31:0]   h2_ff, h2_in;
   logic [31:0]   mx_ff, my_ff, mz_ff;
   logic [49:0]   sq_in;
   logic [31:0]   h_mix;

   function automatic logic [48:0] axis_sq(input logic [15:0] field,
                                           input logic [24:0] frac,
                                           input int d);
      logic signed [27:0] v;
      logic        [26:0] a;
      begin
         v = 28'(d) * 28'sd16777216 + $signed({4'd0, field, 8'd0})
             - $signed({3'd0, frac});
         a = v[27] ? 27'(-v) : 27'(v);
         if (a > 27'd16777216) a = 27'd16777216;
         axis_sq = 49'(a) * 49'(a);
      end
   endfunction

   always_comb begin
      h1_in = s1_ff.seed ^ mx_ff ^ my_ff ^ mz_ff;
      h_mix = h1_ff ^ (h1_ff >> 15);
      h2_in = h_mix * HashMulMix;
   end

   logic [31:0] hf;
   logic [48:0] qx_ff, qy_ff, qz_ff;
   always_comb begin
      hf     = h2_ff ^ (h2_ff >> 13);
      sq_in  = 50'(qx_ff) + 50'(qy_ff) + 50'(qz_ff);
      out_in = s4_ff;
      if (sq_in < s4_ff.best) out_in.best = sq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         item_out.valid <= 1'b0;
      end else if (advance) begin
         s1_ff    <= item_in;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
         s4_ff    <= s3_ff;
         item_out <= out_in;
      end
      if (advance) begin
         mx_ff <= (item_in.cell_x + OffX) * HashMulX;
         my_ff <= (item_in.cell_y + OffY) * HashMulY;
         mz_ff <= (item_in.cell_z + OffZ) * HashMulZ;
         h1_ff <= h1_in;
         h2_ff <= h2_in;
         qx_ff <= axis_sq(hf[15:0],  s3_ff.frac_x, DX);
         qy_ff <= axis_sq(hf[23:8],  s3_ff.frac_y, DY);
         qz_ff <= axis_sq(hf[31:16], s3_ff.frac_z, DZ);
      end
   end
endmodule

FILE: design/cn3d_root.sv
// One bit of the restoring square root per stage.
module cn3d_root #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cn3d_pkg::cn3d_root_type item_in,
   output cn3d_pkg::cn3d_root_type item_out
);
   import cn3d_pkg::*;

   localparam int Shift = 2 * (RootSteps - 1 - STEP);

   logic [SqWidth-1:0] trial;
   logic               take;
   always_comb begin
      trial = {22'd0, item_in.root, 2'b01} << Shift;
      take  = (item_in.rem >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_out.valid <= 1'b0;
      end else if (advance) begin
         item_out.valid <= item_in.valid;
         item_out.rem   <= take ? item_in.rem - trial : item_in.rem;
         item_out.root  <= {item_in.root[RootWidth-2:0], take};
      end
   end
endmodule

FILE: tb/cellular_noise_3d_top_tb.sv
module cellular_noise_3d_top_tb;
   import cn3d_pkg::*;

   localparam int FracBits   = 16;
   localparam int LatCycles  = 27 * 5 + 17 + 1;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_coord_x = '0;
   logic [31:0] req_coord_y = '0;
   logic [31:0] req_coord_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [16:0] rsp_nearest_distance;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_hash_seed = '0;

   logic [31:0] seed_shadow = 32'd255;
   logic [16:0] distance_queue[$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          error_count = 0;
   int          request_count = 0;
   int          checked_count = 0;
   int          cycle_count = 0;

   cellular_noise_3d_top #(.FRAC_BITS(FracBits)) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .req_coord_z         (req_coord_z),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_nearest_distance(rsp_nearest_distance),
      .csr_write_enable    (csr_write_enable),
      .csr_hash_seed       (csr_hash_seed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] hash_cell(logic [31:0] seed, logic [31:0] cx,
                                             logic [31:0] cy, logic [31:0] cz);
      logic [31:0] h;
      h = seed ^ (cx * HashMulX) ^ (cy * HashMulY) ^ (cz * HashMulZ);
      h = h ^ (h >> 15);
      h = h * HashMulMix;
      h = h ^ (h >> 13);
      return h;
   endfunction

   function automatic logic [63:0] axis_square(int d, logic [15:0] field, logic [24:0] frac);
      longint v;
      longint one;
      one = longint'(1) << WorkFrac;
      v = d * one + (longint'(field) << 8) - longint'(frac);
      if (v < 0) v = -v;
      if (v > one) v = one;
      return 64'(v * v);
   endfunction

   function automatic logic [16:0] nearest_distance(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
      logic [31:0] cx, cy, cz, h;
      logic [24:0] fx, fy, fz;
      logic [63:0] best, s, n, root, bit_pos;
      cx = 32'($signed(x) >>> FracBits);
      cy = 32'($signed(y) >>> FracBits);
      cz = 32'($signed(z) >>> FracBits);
      fx = 25'(x[FracBits-1:0]) << (WorkFrac - FracBits);
      fy = 25'(y[FracBits-1:0]) << (WorkFrac - FracBits);
      fz = 25'(z[FracBits-1:0]) << (WorkFrac - FracBits);
      best = '1;
      for (int dx = -1; dx <= 1; dx++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++) begin
               h = hash_cell(seed_shadow, cx + 32'(dx), cy + 32'(dy), cz + 32'(dz));
               s = axis_square(dx, h[15:0], fx) + axis_square(dy, h[23:8], fy)
                 + axis_square(dz, h[31:16], fz);
               if (s < best) best = s;
            end
      // bitwise integer square root
      n = best >> 16;
      root = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > n) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (n >= root + bit_pos) begin
            n = n - (root + bit_pos);
            root = (root >> 1) + bit_pos;
         end else begin
            root >>= 1;
         end
         bit_pos >>= 2;
      end
      if (root > 64'd65536) root = 64'd65536;
      return root[16:0];
   endfunction

   task automatic send_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      // drop valid only while idling, so it is written once per time step
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      distance_queue.push_back(nearest_distance(x, y, z));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (distance_queue.size() != 0) @(posedge clock);
      repeat (LatCycles + 10) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] value);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_hash_seed    <= value;
      seed_shadow = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(64)) - 32) << FracBits | 32'($urandom_range(65535));
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         default: return {$urandom_range(1) ? 16'h8000 : 16'h7FFF, 16'($urandom())};
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] edges[8];
      edges = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 8; i++) send_request(edges[i], edges[i], edges[i]);
      for (int i = 0; i < 8; i++) send_request(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
      send_request(32'hAAAA_5555, 32'h5555_AAAA, 32'h0F0F_F0F0);
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_request(random_coord(), random_coord(), random_coord());
   endtask

   task automatic test_seeds();
      write_seed(32'h0);
      test_random(100, 0, 0);
      write_seed(32'hFFFF_FFFF);
      test_random(100, 9, 9);
      write_seed($urandom());
      test_random(100, 53, 0);
      write_seed(32'd255);
      test_random(100, 0, 53);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (distance_queue.size() == 0) begin
            $display("%0t: unexpected result %0d", $time, rsp_nearest_distance);
            error_count++;
         end else begin
            if (rsp_nearest_distance !== distance_queue[0]) begin
               $display("%0t: nearest_distance expected %0d actual %0d", $time,
                        distance_queue[0], rsp_nearest_distance);
               error_count++;
            end
            void'(distance_queue.pop_front());
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 0, 0);
      test_random(300, 53, 0);
      test_random(300, 0, 53);
      test_random(300, 9, 9);
      test_seeds();
      drain_and_settle();
      if (distance_queue.size() != 0) error_count++;
      $display("Sent %0d requests over four seeds and four idle mixes; %0d results checked.",
               request_count, checked_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
